// ===== hdl/cne_pkg.sv =====
// ----------------------------------------------------------------------------
// cne_pkg
// Shared types and constants for the console number entry unit.
// ----------------------------------------------------------------------------
package cne_pkg;

  localparam int VALUE_WIDTH_DEF = 64;
  localparam int KEY_W           = 8;
  localparam int BASE_W          = 5;
  localparam int CNT_DIGITS_W    = 5;
  localparam int CFG_INDEX_W     = 1;
  localparam int CFG_DATA_W      = 5;
  localparam int STATUS_W        = 2;
  localparam int ECHO_W          = 2;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_NUMBER_BASE = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_MAX_DIGITS  = 1'd1;

  localparam logic [BASE_W-1:0]       BASE_RESET  = 5'd16;
  localparam logic [BASE_W-1:0]       BASE_MIN    = 5'd2;
  localparam logic [BASE_W-1:0]       BASE_HEX    = 5'd16;
  localparam logic [CNT_DIGITS_W-1:0] DIGITS_RESET = 5'd16;

  // key codes
  localparam logic [KEY_W-1:0] KEY_BS     = 8'h08;
  localparam logic [KEY_W-1:0] KEY_CR     = 8'h0D;
  localparam logic [KEY_W-1:0] KEY_ESCAPE = 8'h1B;
  localparam logic [KEY_W-1:0] KEY_SPACE  = 8'h20;
  localparam logic [KEY_W-1:0] KEY_0      = 8'h30;
  localparam logic [KEY_W-1:0] KEY_9      = 8'h39;
  localparam logic [KEY_W-1:0] KEY_A_LC   = 8'h61;
  localparam logic [KEY_W-1:0] KEY_F_LC   = 8'h66;
  localparam logic [KEY_W-1:0] KEY_X_LC   = 8'h78;
  // 'a' maps to ten: subtract ('a' - '9' - 1) + '0'
  localparam logic [KEY_W-1:0] LETTER_BIAS = 8'h57;

  // result codes
  localparam logic [STATUS_W-1:0] ST_ENTERING = 2'd0;
  localparam logic [STATUS_W-1:0] ST_COMPLETE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd2;
  localparam logic [STATUS_W-1:0] ST_ESCAPED  = 2'd3;

  localparam logic [ECHO_W-1:0] ECHO_NONE  = 2'd0;
  localparam logic [ECHO_W-1:0] ECHO_KEY   = 2'd1;
  localparam logic [ECHO_W-1:0] ECHO_ERASE = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MUL,
    S_DIV,
    S_FINISH
  } state_t;

endpackage

// ===== hdl/cne_if.sv =====
// ----------------------------------------------------------------------------
// cne_key_if / cne_result_if
// Valid/ready channels for key codes and entry results.
// ----------------------------------------------------------------------------
interface cne_key_if
  import cne_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [KEY_W-1:0] key_code;

  modport source (output valid, output key_code, input ready);
  modport sink   (input valid, input key_code, output ready);
endinterface

interface cne_result_if
  import cne_pkg::*;
#(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) ();
  logic                   valid;
  logic                   ready;
  logic [STATUS_W-1:0]    entry_status;
  logic [VALUE_WIDTH-1:0] entered_value;
  logic [ECHO_W-1:0]      echo_action;

  modport source (output valid, output entry_status, output entered_value,
                  output echo_action, input ready);
  modport sink   (input valid, input entry_status, input entered_value,
                  input echo_action, output ready);
endinterface

// ===== hdl/console_number_entry_unit.sv =====
// ----------------------------------------------------------------------------
// Key transfer to result valid: a digit runs 5 shift-add steps in S_MUL, one per
//   base bit, then the output load in S_FINISH; an erase with digits entered runs one
//   restoring divide step per value bit in S_DIV, then the load; any other key goes to the load.
// Throughput: one key at a time on the shared unit; the next key is accepted only
//   after the result is loaded, which waits while the result stalls.
// Reset (rst, synchronous): entry cleared, base 16, digit limit 16, no result.
// ----------------------------------------------------------------------------
// console_number_entry_unit
// Builds an unsigned number from console key codes in a configurable base.
// ----------------------------------------------------------------------------
module console_number_entry_unit
  import cne_pkg::*;
#(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  cne_key_if.sink                key,
  cne_result_if.source           result
);

  localparam int STEP_W = $clog2(VALUE_WIDTH);
  localparam int BIDX_W = $clog2(BASE_W);
  localparam logic [STEP_W-1:0] MUL_LAST_STEP = STEP_W'(BASE_W - 1);
  localparam logic [STEP_W-1:0] DIV_LAST_STEP = STEP_W'(VALUE_WIDTH - 1);

  // configuration
  logic [BASE_W-1:0]       number_base;
  logic [CNT_DIGITS_W-1:0] max_digits;

  // entry state
  state_t                  state, state_next;
  logic [VALUE_WIDTH-1:0]  acc, acc_next;
  logic [CNT_DIGITS_W-1:0] digits, digits_next;

  // shared unit working registers
  logic [VALUE_WIDTH-1:0]  work, work_next;   // product / quotient shifter
  logic [3:0]              rem, rem_next;     // divide remainder, below base
  logic [3:0]              dval, dval_next;
  logic [STEP_W-1:0]       step, step_next;

  // pending result, then output register
  logic [STATUS_W-1:0]     res_status, res_status_next;
  logic [VALUE_WIDTH-1:0]  res_value, res_value_next;
  logic [ECHO_W-1:0]       res_echo, res_echo_next;
  logic                    out_valid, out_valid_next;
  logic [STATUS_W-1:0]     out_status;
  logic [VALUE_WIDTH-1:0]  out_value;
  logic [ECHO_W-1:0]       out_echo;
  logic                    out_load;

  // decode
  logic [BASE_W-1:0]       base;
  logic [CNT_DIGITS_W-1:0] limit;
  logic                    hex;
  logic                    is_dec, is_hex_letter, is_digit, is_erase, is_end;
  logic [3:0]              dec_val, hex_val;
  logic                    accept;

  // shared arithmetic
  logic [VALUE_WIDTH-1:0]  addend, digit_add;
  logic [BASE_W-1:0]       trial;
  logic                    trial_ge;
  logic [CNT_DIGITS_W-1:0] digits_inc;

  function automatic logic number_bit(input logic [BASE_W-1:0] b,
                                      input logic [STEP_W-1:0] s);
    number_bit = b[s[BIDX_W-1:0]];
  endfunction

  // effective base clamped to 2..16, zero limit acts as one
  always_comb begin
    if (number_base < BASE_MIN) begin
      base = BASE_MIN;
    end else if (number_base > BASE_HEX) begin
      base = BASE_HEX;
    end else begin
      base = number_base;
    end
    limit = (max_digits == '0) ? CNT_DIGITS_W'(1) : max_digits;
  end

  assign hex           = (base == BASE_HEX);
  assign accept        = key.valid && key.ready;
  assign is_dec        = (key.key_code >= KEY_0) && (key.key_code <= KEY_9);
  assign is_hex_letter = hex && (key.key_code >= KEY_A_LC) && (key.key_code <= KEY_F_LC);
  assign is_digit      = is_dec || is_hex_letter;
  // 'x' after a zero hex digit erases it so that "0x" prefixes paste cleanly
  assign is_erase      = (key.key_code == KEY_BS) ||
                         ((key.key_code == KEY_X_LC) && hex && (acc[3:0] == 4'd0));
  assign is_end        = (key.key_code == KEY_SPACE) || (key.key_code == KEY_CR);
  assign dec_val       = 4'(key.key_code - KEY_0);
  assign hex_val       = 4'(key.key_code - LETTER_BIAS);

  // multiply step: Horner over base bits, MSB first; digit folded into last step
  assign addend    = number_bit(base, step) ? acc : '0;
  assign digit_add = (step == '0) ? VALUE_WIDTH'(dval) : '0;

  // divide step: restoring, one quotient bit per cycle
  assign trial    = {rem, work[VALUE_WIDTH-1]};
  assign trial_ge = (trial >= base);

  assign digits_inc = digits + CNT_DIGITS_W'(1);

  assign key.ready = (state == S_IDLE);
  assign out_load  = (state == S_FINISH) && (!out_valid || result.ready);

  always_comb begin
    state_next      = state;
    acc_next        = acc;
    digits_next     = digits;
    work_next       = work;
    rem_next        = rem;
    dval_next       = dval;
    step_next       = step;
    res_status_next = res_status;
    res_value_next  = res_value;
    res_echo_next   = res_echo;
    out_valid_next  = out_valid;

    if (out_valid && result.ready) begin
      out_valid_next = 1'b0;
    end

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          res_status_next = ST_ENTERING;
          res_value_next  = acc;
          res_echo_next   = ECHO_NONE;
          state_next      = S_FINISH;
          priority if (is_digit) begin
            dval_next  = is_dec ? dec_val : hex_val;
            work_next  = '0;
            step_next  = MUL_LAST_STEP;
            state_next = S_MUL;
          end else if (is_erase) begin
            if (digits != '0) begin
              work_next  = acc;
              rem_next   = '0;
              step_next  = DIV_LAST_STEP;
              state_next = S_DIV;
            end
          end else if (is_end) begin
            res_status_next = (digits != '0) ? ST_COMPLETE : ST_EMPTY;
            res_value_next  = (digits != '0) ? acc : '0;
            acc_next        = '0;
            digits_next     = '0;
          end else if (key.key_code == KEY_ESCAPE) begin
            res_status_next = ST_ESCAPED;
            res_value_next  = '0;
            acc_next        = '0;
            digits_next     = '0;
          end else begin
            // ignored key: report current value
          end
        end
      end

      S_MUL: begin
        work_next = (work << 1) + addend + digit_add;
        step_next = step - STEP_W'(1);
        if (step == '0) begin
          res_value_next = work_next;
          res_echo_next  = ECHO_KEY;
          state_next     = S_FINISH;
          if (digits_inc >= limit) begin
            res_status_next = ST_COMPLETE;
            acc_next        = '0;
            digits_next     = '0;
          end else begin
            res_status_next = ST_ENTERING;
            acc_next        = work_next;
            digits_next     = digits_inc;
          end
        end
      end

      S_DIV: begin
        rem_next  = trial_ge ? 4'(trial - base) : trial[3:0];
        work_next = {work[VALUE_WIDTH-2:0], trial_ge};
        step_next = step - STEP_W'(1);
        if (step == '0) begin
          acc_next        = work_next;
          digits_next     = digits - CNT_DIGITS_W'(1);
          res_status_next = ST_ENTERING;
          res_value_next  = work_next;
          res_echo_next   = ECHO_ERASE;
          state_next      = S_FINISH;
        end
      end

      S_FINISH: begin
        if (out_load) begin
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      acc         <= '0;
      digits      <= '0;
      out_valid   <= 1'b0;
      number_base <= BASE_RESET;
      max_digits  <= DIGITS_RESET;
    end else begin
      state     <= state_next;
      acc       <= acc_next;
      digits    <= digits_next;
      out_valid <= out_valid_next;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_NUMBER_BASE: number_base <= cfg_wdata;
          CFG_MAX_DIGITS:  max_digits  <= cfg_wdata;
          default: begin
          end
        endcase
      end
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    work       <= work_next;
    rem        <= rem_next;
    dval       <= dval_next;
    step       <= step_next;
    res_status <= res_status_next;
    res_value  <= res_value_next;
    res_echo   <= res_echo_next;
    if (out_load) begin
      out_status <= res_status;
      out_value  <= res_value;
      out_echo   <= res_echo;
    end
  end

  assign result.valid         = out_valid;
  assign result.entry_status  = out_status;
  assign result.entered_value = out_value;
  assign result.echo_action   = out_echo;

endmodule
